>>> src/multi_channel_deadline_timer_unit_defines.svh
// ----------------------------------------------------------------------------
// Deadline timer unit assertion macros
// Clocked, reset-gated concurrent assertion helpers for the timer unit.
// ----------------------------------------------------------------------------
`ifndef MULTI_CHANNEL_DEADLINE_TIMER_UNIT_DEFINES_SVH
`define MULTI_CHANNEL_DEADLINE_TIMER_UNIT_DEFINES_SVH

// assert a property on an explicit clock and active-low reset
`define MCDT_ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// assert a property on the unit's own clock and reset
`define MCDT_ASSERT(label, prop, msg) \
  `MCDT_ASSERT_CLK(label, clk_i, rst_ni, prop, msg)

`endif

>>> src/mcdt_pkg.sv
// ----------------------------------------------------------------------------
// Deadline timer package
// Sizes, command codes, interval table and time helpers for the timer unit.
// ----------------------------------------------------------------------------
`default_nettype none

package mcdt_pkg;

  localparam int unsigned NUM_CHANNELS = 21;
  localparam int unsigned TIME_BITS    = 32;

  localparam int unsigned ChanW    = 5;
  localparam int unsigned MsW      = 16;
  localparam int unsigned ScaleW   = 16;
  localparam int unsigned GameW    = 32;
  localparam int unsigned ProdW    = MsW + ScaleW;
  localparam int unsigned FracW    = 8;
  localparam int unsigned ScaledW  = ProdW - FracW;
  localparam int unsigned IntW     = 9;
  localparam int unsigned TableLen = 21;
  localparam int unsigned ChIdxW   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int unsigned ChExtW   = (ChIdxW > ChanW) ? ChIdxW : ChanW;

  localparam logic [ScaleW-1:0] ScaleReset = ScaleW'(256);

  typedef enum logic [2:0] {
    CmdTick         = 3'd0,
    CmdResetChannel = 3'd1,
    CmdCheckChannel = 3'd2,
    CmdSetPause     = 3'd3,
    CmdArmCustom    = 3'd4,
    CmdCheckCustom  = 3'd5
  } cmd_e;

  typedef logic [TIME_BITS-1:0] time_t;

  localparam logic [IntW-1:0] IntervalTable [TableLen] = '{
    9'd5,   9'd20,  9'd200, 9'd200, 9'd80,  9'd150, 9'd300,
    9'd300, 9'd300, 9'd200, 9'd150, 9'd20,  9'd100, 9'd20,
    9'd40,  9'd500, 9'd250, 9'd500, 9'd400, 9'd10,  9'd100
  };

  function automatic logic [IntW-1:0] interval_of(input logic [ChExtW-1:0] ch);
    logic [IntW-1:0] val;
    val = '0;
    if (ch < ChExtW'(TableLen)) begin
      val = IntervalTable[ch[4:0]];
    end
    return val;
  endfunction

  // deadline reached when the wrapping difference is not negative
  function automatic logic passed(input time_t now, input time_t deadline);
    time_t diff;
    diff = now - deadline;
    return !diff[TIME_BITS-1];
  endfunction

endpackage

`default_nettype wire

>>> src/multi_channel_deadline_timer_unit.sv
// ----------------------------------------------------------------------------
// Multi-channel deadline timer unit
// Bank of fixed-interval timers plus one one-shot timer on a shared clock.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the in_valid_i / in_ready_o channel with a command and
//   its operands; every request yields exactly one result on the
//   out_valid_o / out_ready_i channel (done_res_o, fire_callback_o and the
//   game clock after the request), in request order.
//   cfg_we_i / cfg_wdata_i write the Q8.8 duration scale; write it only while
//   no request is in flight.
//   Flow: an accepted request moves on from the request register to the
//   result register once it is empty or being read. Throughput: one
//   request per cycle while out_ready_i is high, set by the single pass of
//   scale multiply, deadline add and compare between the two registers.
//   Reset: reference time, game clock, all deadlines and the one-shot are
//   cleared (every channel reads expired), pause is off, scale is 1.0.
//   Stall: while out_ready_i is low the result holds, the request register
//   holds one request behind it, and in_ready_o drops once both are full.
// ----------------------------------------------------------------------------
`default_nettype none

`include "multi_channel_deadline_timer_unit_defines.svh"

module multi_channel_deadline_timer_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [mcdt_pkg::ScaleW-1:0] cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [2:0]                  command_i,
  input  logic [mcdt_pkg::MsW-1:0]    elapsed_ms_i,
  input  logic [mcdt_pkg::ChanW-1:0]  channel_i,
  input  logic                        auto_reset_i,
  input  logic                        pause_request_i,
  input  logic [mcdt_pkg::MsW-1:0]    delay_ms_i,
  input  logic                        replace_i,
  input  logic                        callback_present_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        done_res_o,
  output logic                        fire_callback_o,
  output logic [mcdt_pkg::GameW-1:0]  game_clock_now_o
);

  // request register
  logic                        req_valid_q;
  logic [2:0]                  cmd_q;
  logic [mcdt_pkg::MsW-1:0]    elapsed_q;
  logic [mcdt_pkg::ChanW-1:0]  chan_q;
  logic                        auto_reset_q;
  logic                        pause_req_q;
  logic [mcdt_pkg::MsW-1:0]    delay_q;
  logic                        replace_q;
  logic                        cb_present_q;

  // timer state
  logic [mcdt_pkg::ScaleW-1:0] scale_q;
  mcdt_pkg::time_t             ref_time_q, ref_time_d;
  logic [mcdt_pkg::GameW-1:0]  game_time_q, game_time_d;
  logic                        paused_q, paused_d;
  mcdt_pkg::time_t             chan_dl_q [mcdt_pkg::NUM_CHANNELS];
  mcdt_pkg::time_t             os_dl_q, os_dl_d;
  logic                        os_armed_q, os_armed_d;

  // result register
  logic                        out_valid_q;
  logic                        done_q, done_d;
  logic                        fire_q, fire_d;
  logic [mcdt_pkg::GameW-1:0]  game_out_q;

  logic                         advance;
  logic [mcdt_pkg::ChExtW-1:0]  ch_ext;
  logic [mcdt_pkg::ChIdxW-1:0]  ch_idx;
  logic                         ch_in_range;
  logic [mcdt_pkg::MsW-1:0]     mul_op;
  logic [mcdt_pkg::ProdW-1:0]   prod;
  mcdt_pkg::time_t              new_dl;
  mcdt_pkg::time_t              chan_dl_rd;
  logic                         chan_we;

  assign advance    = req_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !req_valid_q || advance;

  assign ch_ext      = mcdt_pkg::ChExtW'(chan_q);
  assign ch_idx      = ch_ext[mcdt_pkg::ChIdxW-1:0];
  assign ch_in_range = ch_ext < mcdt_pkg::ChExtW'(mcdt_pkg::NUM_CHANNELS);
  assign chan_dl_rd  = chan_dl_q[ch_idx];

  assign mul_op = (cmd_q == mcdt_pkg::CmdArmCustom) ? delay_q
                : mcdt_pkg::MsW'(mcdt_pkg::interval_of(ch_ext));
  assign prod   = mcdt_pkg::ProdW'(mul_op) * mcdt_pkg::ProdW'(scale_q);
  assign new_dl = ref_time_q
                + mcdt_pkg::TIME_BITS'(prod[mcdt_pkg::ProdW-1:mcdt_pkg::FracW]);

  always_comb begin
    ref_time_d  = ref_time_q;
    game_time_d = game_time_q;
    paused_d    = paused_q;
    os_dl_d     = os_dl_q;
    os_armed_d  = os_armed_q;
    chan_we     = 1'b0;
    done_d      = 1'b0;
    fire_d      = 1'b0;
    case (mcdt_pkg::cmd_e'(cmd_q))
      mcdt_pkg::CmdTick: begin
        ref_time_d = ref_time_q + mcdt_pkg::TIME_BITS'(elapsed_q);
        if (!paused_q) begin
          game_time_d = game_time_q + mcdt_pkg::GameW'(elapsed_q);
        end
      end
      mcdt_pkg::CmdResetChannel: begin
        chan_we = ch_in_range;
      end
      mcdt_pkg::CmdCheckChannel: begin
        if (ch_in_range && !paused_q && mcdt_pkg::passed(ref_time_q, chan_dl_rd)) begin
          done_d  = 1'b1;
          chan_we = auto_reset_q;
        end
      end
      mcdt_pkg::CmdSetPause: begin
        paused_d = pause_req_q;
      end
      mcdt_pkg::CmdArmCustom: begin
        fire_d     = !replace_q && os_armed_q;
        os_dl_d    = new_dl;
        os_armed_d = cb_present_q;
      end
      mcdt_pkg::CmdCheckCustom: begin
        if (os_armed_q && !paused_q && mcdt_pkg::passed(ref_time_q, os_dl_q)) begin
          os_dl_d    = ref_time_q;
          os_armed_d = 1'b0;
          fire_d     = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      req_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      cmd_q        <= command_i;
      elapsed_q    <= elapsed_ms_i;
      chan_q       <= channel_i;
      auto_reset_q <= auto_reset_i;
      pause_req_q  <= pause_request_i;
      delay_q      <= delay_ms_i;
      replace_q    <= replace_i;
      cb_present_q <= callback_present_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= mcdt_pkg::ScaleReset;
    end else if (cfg_we_i) begin
      scale_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_time_q  <= '0;
      game_time_q <= '0;
      paused_q    <= 1'b0;
      os_dl_q     <= '0;
      os_armed_q  <= 1'b0;
      for (int i = 0; i < mcdt_pkg::NUM_CHANNELS; i++) begin
        chan_dl_q[i] <= '0;
      end
    end else if (advance) begin
      ref_time_q  <= ref_time_d;
      game_time_q <= game_time_d;
      paused_q    <= paused_d;
      os_dl_q     <= os_dl_d;
      os_armed_q  <= os_armed_d;
      if (chan_we) begin
        chan_dl_q[ch_idx] <= new_dl;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      done_q     <= done_d;
      fire_q     <= fire_d;
      game_out_q <= game_time_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign done_res_o       = done_q;
  assign fire_callback_o  = fire_q;
  assign game_clock_now_o = game_out_q;

  `MCDT_ASSERT(a_done_fire_excl, out_valid_q |-> !(done_q && fire_q), "done and fire together")
  `MCDT_ASSERT(a_no_done_paused, (advance && paused_q) |=> !done_res_o, "expiry while paused")
  `MCDT_ASSERT(a_game_frozen, (advance && paused_q) |=> (game_clock_now_o == $past(game_time_q)), "game clock moved while paused")
  `MCDT_ASSERT(a_state_hold, (!advance) |=> (ref_time_q == $past(ref_time_q)), "reference time moved without a request")

endmodule

`default_nettype wire
